/* src/mlts_pkg.sv */
// Shared types, sizes, codes and rounding helpers for the mesh smoother.
// Used by mlts_update and by the top level mesh_laplacian_taubin_smoother.
package mlts_pkg;

	// Mesh sizes.
	localparam int VTX_N   = 1024;
	localparam int VTX_W   = 10;
	localparam int NB_N    = 16;
	localparam int NB_W    = 4;
	localparam int CNT_W   = 5;
	localparam int NBL_AW  = VTX_W + NB_W;
	localparam int NBL_N   = VTX_N * NB_N;

	// Field widths.
	localparam int POS_W   = 32;
	localparam int POS3_W  = 3 * POS_W;
	localparam int NRM_W   = 16;
	localparam int NRM3_W  = 3 * NRM_W;
	localparam int GAIN_W  = 17;
	localparam int FAC_W   = 18;
	localparam int SUM_W   = POS_W + NB_W;
	localparam int PASS_W  = 9;
	localparam int VTOT_W  = 11;
	localparam int ATTR_W  = NRM3_W + GAIN_W + 1;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 17;
	localparam int GAIN_FRAC = 16;
	localparam int NORM_FRAC = 14;

	// Commands.
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_RUN  = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_READ = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_ERR  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_ENVELOPE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PASSES   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MAINTAIN = 3'd2;
	localparam logic [CFG_AW-1:0] REG_EDGES    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_MODE     = 3'd4;
	localparam logic [CFG_AW-1:0] REG_LAMBDA   = 3'd5;
	localparam logic [CFG_AW-1:0] REG_MU       = 3'd6;
	localparam logic [CFG_AW-1:0] REG_VTOTAL   = 3'd7;

	typedef struct packed {
		logic [1:0]              command;
		logic [VTX_W-1:0]        vertex_index;
		logic [VTX_W-1:0]        neighbor_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic [GAIN_W-1:0]       paint_weight;
		logic                    on_border;
	} item_t;

	typedef struct packed {
		logic [VTX_W-1:0]        result_index;
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [POS_W-1:0] out_z;
		logic [1:0]              status;
	} result_t;

	// Request to the vertex update unit; operands hold while it works.
	typedef struct packed {
		logic                start;
		logic [SUM_W-1:0]    sum_x;
		logic [SUM_W-1:0]    sum_y;
		logic [SUM_W-1:0]    sum_z;
		logic [CNT_W-1:0]    count;
		logic [POS3_W-1:0]   pos;
		logic [NRM3_W-1:0]   normal;
		logic [GAIN_W-1:0]   weight;
		logic [GAIN_W-1:0]   envelope;
		logic [FAC_W-1:0]    factor;
		logic [GAIN_W-1:0]   maintain;
	} upd_req_t;

	typedef struct packed {
		logic              done;
		logic [POS3_W-1:0] pos;
	} upd_rsp_t;

	// Round to nearest, ties away from zero, after a right shift by s.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		else
			return -((-v + half) >>> s);
	endfunction

	// Saturate to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

/* src/mlts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module mlts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* src/mlts_update.sv */
// Multi-cycle position update of one vertex: average, gain, offset, normal bias.
// Depends on mlts_pkg for types, sizes and rounding helpers.
module mlts_update import mlts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  upd_req_t req,
	output upd_rsp_t rsp
);

	localparam logic [3:0] U_IDLE = 4'd0;
	localparam logic [3:0] U_KG   = 4'd1;
	localparam logic [3:0] U_G    = 4'd2;
	localparam logic [3:0] U_DIV  = 4'd3;
	localparam logic [3:0] U_D    = 4'd4;
	localparam logic [3:0] U_DMUL = 4'd5;
	localparam logic [3:0] U_O    = 4'd6;
	localparam logic [3:0] U_SQ   = 4'd7;
	localparam logic [3:0] U_SS   = 4'd8;
	localparam logic [3:0] U_SQRT = 4'd9;
	localparam logic [3:0] U_M    = 4'd10;
	localparam logic [3:0] U_NM   = 4'd11;
	localparam logic [3:0] U_P    = 4'd12;

	logic [3:0]                state_q;
	logic                      done_q;
	logic [5:0]                bit_q;
	logic [2*GAIN_W-1:0]       kprod_q;
	logic signed [37:0]        gprod_q;
	logic signed [21:0]        g_q;
	logic [SUM_W-1:0]          mag_q  [3];
	logic [CNT_W-1:0]          rem_q  [3];
	logic                      neg_q  [3];
	logic signed [POS_W:0]     d_q    [3];
	logic signed [54:0]        dprod_q[3];
	logic signed [POS_W-1:0]   o_q    [3];
	logic [63:0]               sq_q   [3];
	logic [63:0]               sv_q;
	logic [63:0]               sr_q;
	logic [63:0]               sb_q;
	logic [48:0]               mprod_q;
	logic signed [50:0]        nprod_q[3];
	logic [POS3_W-1:0]         npos_q;

	logic [SUM_W-1:0]          sum_in [3];
	logic signed [POS_W-1:0]   pos_in [3];
	logic signed [NRM_W-1:0]   nrm_in [3];

	assign sum_in[0] = req.sum_x;
	assign sum_in[1] = req.sum_y;
	assign sum_in[2] = req.sum_z;

	// Unpack the per-component operands, x in the upper bits.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pos_in[c] = $signed(req.pos[(2 - c) * POS_W +: POS_W]);
			nrm_in[c] = $signed(req.normal[(2 - c) * NRM_W +: NRM_W]);
		end
	end

	// Control sequence of the update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: if (req.start) state_q <= U_KG;
				U_KG:   state_q <= U_G;
				U_G: begin
					state_q <= U_DIV;
					bit_q   <= 6'(SUM_W - 1);
				end
				U_DIV: begin
					bit_q <= bit_q - 6'd1;
					if (bit_q == '0)
						state_q <= U_D;
				end
				U_D:    state_q <= U_DMUL;
				U_DMUL: state_q <= U_O;
				U_O:    state_q <= U_SQ;
				U_SQ:   state_q <= U_SS;
				U_SS:   state_q <= U_SQRT;
				U_SQRT: if (sb_q == 64'd1) state_q <= U_M;
				U_M:    state_q <= U_NM;
				U_NM:   state_q <= U_P;
				U_P: begin
					state_q <= U_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Datapath: one arithmetic step per state, done for all three components where needed.
	always_ff @(posedge clk) begin
		logic [SUM_W:0]          rs;
		logic signed [SUM_W:0]   avg;
		logic signed [37:0]      dw;
		logic [63:0]             t;
		logic signed [63:0]      rv;
		logic signed [63:0]      acc;
		case (state_q)
			U_IDLE: begin
				// Envelope times paint weight; divider lanes start on |sum|.
				kprod_q <= req.envelope * req.weight;
				for (int c = 0; c < 3; c++) begin
					neg_q[c] <= sum_in[c][SUM_W-1];
					mag_q[c] <= sum_in[c][SUM_W-1] ? -sum_in[c] : sum_in[c];
					rem_q[c] <= '0;
				end
			end
			U_KG: begin
				rv = rnd_shift(64'(kprod_q), GAIN_FRAC);
				gprod_q <= $signed({1'b0, rv[18:0]}) * $signed(req.factor);
			end
			U_G: begin
				rv = rnd_shift(64'(gprod_q), GAIN_FRAC);
				g_q <= rv[21:0];
			end
			U_DIV: begin
				// Restoring division, one quotient bit per lane per cycle.
				for (int c = 0; c < 3; c++) begin
					rs = {rem_q[c], mag_q[c][SUM_W-1]};
					if (rs >= {1'b0, req.count}) begin
						rem_q[c] <= CNT_W'(rs - {1'b0, req.count});
						mag_q[c] <= {mag_q[c][SUM_W-2:0], 1'b1};
					end else begin
						rem_q[c] <= CNT_W'(rs);
						mag_q[c] <= {mag_q[c][SUM_W-2:0], 1'b0};
					end
				end
			end
			U_D: begin
				// Average truncated toward zero, minus own position.
				for (int c = 0; c < 3; c++) begin
					avg = neg_q[c] ? -$signed({1'b0, mag_q[c]}) : $signed({1'b0, mag_q[c]});
					dw = 38'(avg) - 38'(pos_in[c]);
					d_q[c] <= dw[POS_W:0];
				end
			end
			U_DMUL: begin
				for (int c = 0; c < 3; c++)
					dprod_q[c] <= d_q[c] * g_q;
			end
			U_O: begin
				for (int c = 0; c < 3; c++)
					o_q[c] <= sat32(rnd_shift(64'(dprod_q[c]), GAIN_FRAC));
			end
			U_SQ: begin
				for (int c = 0; c < 3; c++) begin
					rv = 64'(o_q[c]) * 64'(o_q[c]);
					sq_q[c] <= rv;
				end
			end
			U_SS: begin
				sv_q <= sq_q[0] + sq_q[1] + sq_q[2];
				sr_q <= '0;
				sb_q <= 64'd1 << 62;
			end
			U_SQRT: begin
				// Integer square root, two radicand bits per cycle.
				t = sr_q + sb_q;
				if (sv_q >= t) begin
					sv_q <= sv_q - t;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			U_M: mprod_q <= sr_q[31:0] * req.maintain;
			U_NM: begin
				rv = rnd_shift(64'(mprod_q), GAIN_FRAC);
				for (int c = 0; c < 3; c++)
					nprod_q[c] <= nrm_in[c] * $signed({1'b0, rv[33:0]});
			end
			U_P: begin
				for (int c = 0; c < 3; c++) begin
					acc = 64'(pos_in[c]) + 64'(o_q[c]) +
						rnd_shift(64'(nprod_q[c]), NORM_FRAC);
					npos_q[(2 - c) * POS_W +: POS_W] <= sat32(acc);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.pos  = npos_q;

endmodule

/* src/mesh_laplacian_taubin_smoother.sv */
// Top level of the Laplacian/Taubin mesh smoother: command decode, vertex walk, memories.
// Depends on mlts_pkg, mlts_ram and mlts_update.
//
//  channel | direction | handshake              | payload
//  item    | in        | item_valid/item_stall  | item_t (command and vertex data)
//  result  | out       | result_valid/result_stall | result_t (index, position, status)
//  cfg     | in        | cfg_we                 | cfg_addr, cfg_wdata
//
// A load is written as it is taken; an add goes through ST_ADD, a read through ST_READ
// and ST_EMIT. A run walks all 1024 vertices each pass: ST_VRD, ST_VCHK and ST_NEXT for
// a vertex that stays put, plus ST_NPOS and ST_NACC per neighbor and a wait in ST_UPDW
// on the update unit for one that moves. Passes repeat per round, twice in mode 1. After
// reset a pass over all 1024 vertices clears the neighbor counts; items stall meanwhile.
// A finished result waits in the output register while the next item is taken.
module mesh_laplacian_taubin_smoother import mlts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ADD   = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_EMIT  = 4'd4;
	localparam logic [3:0] ST_VRD   = 4'd5;
	localparam logic [3:0] ST_VCHK  = 4'd6;
	localparam logic [3:0] ST_NPOS  = 4'd7;
	localparam logic [3:0] ST_NACC  = 4'd8;
	localparam logic [3:0] ST_UPDW  = 4'd9;
	localparam logic [3:0] ST_NEXT  = 4'd10;

	// Configuration registers.
	logic [GAIN_W-1:0] env_q, maintain_q, lambda_q, mu_q;
	logic [PASS_W-1:0] passes_q;
	logic              edges_q, mode_q;
	logic [VTOT_W-1:0] vtotal_q;

	// Control state.
	logic [3:0]        state_q;
	logic [VTX_W-1:0]  clr_q;
	logic [VTX_W-1:0]  v_q;
	logic [PASS_W-1:0] pass_q;
	logic              round_q;
	logic              cur_bank_q;
	logic [CNT_W-1:0]  idx_q;
	logic              upd_start_q;
	logic              out_valid_q;

	// Payload registers.
	item_t             req_q;
	result_t           res_q;
	result_t           out_q;
	logic [POS3_W-1:0] own_pos_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CNT_W-1:0]  ncnt_q;
	logic [SUM_W-1:0]  sum_q [3];

	// Memory ports.
	logic              pos0_we, pos1_we, attr_we, nbl_we, cnt_we;
	logic [VTX_W-1:0]  pos_waddr, pos_raddr, vtx_raddr, cnt_waddr;
	logic [POS3_W-1:0] pos_wdata, pos0_rdata, pos1_rdata, cur_pos;
	logic [ATTR_W-1:0] attr_wdata, attr_rdata;
	logic [NBL_AW-1:0] nbl_waddr, nbl_raddr;
	logic [VTX_W-1:0]  nbl_rdata;
	logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

	logic              item_fire, emit_fire, walk, run_we, load_we, add_ok;
	logic [CNT_W-1:0]  idx_nxt;
	logic [FAC_W-1:0]  factor;
	upd_req_t          upd_req;
	upd_rsp_t          upd_rsp;

	assign item_stall = (state_q != ST_IDLE);
	assign item_fire  = item_valid && !item_stall;
	assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || !result_stall);
	assign cur_pos    = cur_bank_q ? pos1_rdata : pos0_rdata;
	assign idx_nxt    = idx_q + CNT_W'(1);
	assign add_ok     = (cnt_rdata < CNT_W'(NB_N));
	assign load_we    = item_fire && (item.command == CMD_LOAD);

	// A vertex moves when it is in use, has neighbors and is not a held border vertex.
	assign walk = ({1'b0, v_q} < vtotal_q) && (cnt_rdata != '0) &&
		!(attr_rdata[0] && !edges_q);
	assign run_we = ((state_q == ST_VCHK) && !walk) || ((state_q == ST_UPDW) && upd_rsp.done);

	// Second round of mode 1 uses mu minus lambda.
	assign factor = round_q ? FAC_W'($signed({1'b0, mu_q}) - $signed({1'b0, lambda_q}))
		: {1'b0, lambda_q};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q      <= GAIN_W'(65536);
			passes_q   <= '0;
			maintain_q <= '0;
			edges_q    <= 1'b0;
			mode_q     <= 1'b0;
			lambda_q   <= GAIN_W'(32768);
			mu_q       <= GAIN_W'(197);
			vtotal_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENVELOPE: env_q      <= cfg_wdata;
				REG_PASSES:   passes_q   <= cfg_wdata[PASS_W-1:0];
				REG_MAINTAIN: maintain_q <= cfg_wdata;
				REG_EDGES:    edges_q    <= cfg_wdata[0];
				REG_MODE:     mode_q     <= cfg_wdata[0];
				REG_LAMBDA:   lambda_q   <= cfg_wdata;
				REG_MU:       mu_q       <= cfg_wdata;
				REG_VTOTAL:   vtotal_q   <= cfg_wdata[VTOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Main sequencer: commands, vertex walk and pass counting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			v_q         <= '0;
			pass_q      <= '0;
			round_q     <= 1'b0;
			cur_bank_q  <= 1'b0;
			idx_q       <= '0;
			upd_start_q <= 1'b0;
		end else begin
			upd_start_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VTX_W'(1);
					if (clr_q == VTX_W'(VTX_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_fire) begin
						case (item.command)
							CMD_ADD:  state_q <= ST_ADD;
							CMD_READ: state_q <= ST_READ;
							CMD_RUN: begin
								if (env_q == '0 || passes_q == '0) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_VRD;
									v_q     <= '0;
									pass_q  <= '0;
									round_q <= 1'b0;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD:  state_q <= add_ok ? ST_IDLE : ST_EMIT;
				ST_READ: state_q <= ST_EMIT;
				ST_EMIT: if (emit_fire) state_q <= ST_IDLE;
				ST_VRD:  state_q <= ST_VCHK;
				ST_VCHK: begin
					idx_q   <= '0;
					state_q <= walk ? ST_NPOS : ST_NEXT;
				end
				ST_NPOS: state_q <= ST_NACC;
				ST_NACC: begin
					idx_q <= idx_nxt;
					if (idx_nxt < ncnt_q) begin
						state_q <= ST_NPOS;
					end else begin
						state_q     <= ST_UPDW;
						upd_start_q <= 1'b1;
					end
				end
				ST_UPDW: if (upd_rsp.done) state_q <= ST_NEXT;
				ST_NEXT: begin
					state_q <= ST_VRD;
					v_q     <= v_q + VTX_W'(1);
					if (v_q == VTX_W'(VTX_N - 1)) begin
						// End of a pass: the freshly written bank becomes current.
						cur_bank_q <= ~cur_bank_q;
						pass_q     <= pass_q + PASS_W'(1);
						if (pass_q + PASS_W'(1) == passes_q) begin
							pass_q <= '0;
							if (!round_q && mode_q)
								round_q <= 1'b1;
							else
								state_q <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result preparation, vertex latches and neighbor sums.
	always_ff @(posedge clk) begin
		if (item_fire)
			req_q <= item;
		case (state_q)
			ST_IDLE: begin
				res_q <= '{result_index: item.vertex_index, out_x: '0, out_y: '0,
					out_z: '0, status: STAT_DONE};
				if (item.command == CMD_RUN)
					res_q.result_index <= '0;
			end
			ST_ADD:
				res_q <= '{result_index: req_q.vertex_index, out_x: '0, out_y: '0,
					out_z: '0, status: STAT_ERR};
			ST_READ:
				res_q <= '{result_index: req_q.vertex_index,
					out_x: cur_pos[3*POS_W-1 -: POS_W],
					out_y: cur_pos[2*POS_W-1 -: POS_W],
					out_z: cur_pos[POS_W-1 -: POS_W], status: STAT_READ};
			ST_VCHK: begin
				own_pos_q <= cur_pos;
				attr_q    <= attr_rdata;
				ncnt_q    <= cnt_rdata;
				for (int c = 0; c < 3; c++)
					sum_q[c] <= '0;
			end
			ST_NACC: begin
				for (int c = 0; c < 3; c++)
					sum_q[c] <= sum_q[c] +
						SUM_W'($signed(cur_pos[(2 - c) * POS_W +: POS_W]));
			end
			ST_NEXT: begin
				if (v_q == VTX_W'(VTX_N - 1)) begin
					res_q <= '{result_index: '0, out_x: '0, out_y: '0,
						out_z: '0, status: STAT_DONE};
				end
			end
			default: ;
		endcase
	end

	// Output register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_fire)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_fire)
			out_q <= res_q;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Memory address and write steering.
	assign vtx_raddr = (state_q == ST_IDLE) ? item.vertex_index : v_q;
	assign pos_raddr = (state_q == ST_NPOS) ? nbl_rdata : vtx_raddr;
	assign pos_waddr = load_we ? item.vertex_index : v_q;
	assign pos_wdata = load_we ? {item.pos_x, item.pos_y, item.pos_z} :
		((state_q == ST_UPDW) ? upd_rsp.pos : cur_pos);
	assign pos0_we   = load_we || (run_we && cur_bank_q);
	assign pos1_we   = load_we || (run_we && !cur_bank_q);

	assign attr_we    = load_we;
	assign attr_wdata = {item.normal_x, item.normal_y, item.normal_z,
		item.paint_weight, item.on_border};

	assign nbl_we    = (state_q == ST_ADD) && add_ok;
	assign nbl_waddr = {req_q.vertex_index, cnt_rdata[NB_W-1:0]};
	assign nbl_raddr = (state_q == ST_NACC) ? {v_q, idx_nxt[NB_W-1:0]} : {v_q, {NB_W{1'b0}}};

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = item.vertex_index;
		cnt_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
			end
			ST_IDLE: cnt_we = load_we;
			ST_ADD: begin
				cnt_we    = add_ok;
				cnt_waddr = req_q.vertex_index;
				cnt_wdata = cnt_rdata + CNT_W'(1);
			end
			default: ;
		endcase
	end

	mlts_ram #(.WIDTH(POS3_W), .DEPTH(VTX_N)) u_pos0 (
		.clk(clk), .we(pos0_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos0_rdata)
	);

	mlts_ram #(.WIDTH(POS3_W), .DEPTH(VTX_N)) u_pos1 (
		.clk(clk), .we(pos1_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos1_rdata)
	);

	mlts_ram #(.WIDTH(ATTR_W), .DEPTH(VTX_N)) u_attr (
		.clk(clk), .we(attr_we), .waddr(item.vertex_index), .wdata(attr_wdata),
		.raddr(vtx_raddr), .rdata(attr_rdata)
	);

	mlts_ram #(.WIDTH(VTX_W), .DEPTH(NBL_N)) u_nbl (
		.clk(clk), .we(nbl_we), .waddr(nbl_waddr), .wdata(req_q.neighbor_index),
		.raddr(nbl_raddr), .rdata(nbl_rdata)
	);

	mlts_ram #(.WIDTH(CNT_W), .DEPTH(VTX_N)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(vtx_raddr), .rdata(cnt_rdata)
	);

	// Vertex update unit.
	assign upd_req = '{start: upd_start_q, sum_x: sum_q[0], sum_y: sum_q[1],
		sum_z: sum_q[2], count: ncnt_q, pos: own_pos_q,
		normal: attr_q[ATTR_W-1 -: NRM3_W], weight: attr_q[GAIN_W:1],
		envelope: env_q, factor: factor, maintain: maintain_q};

	mlts_update u_update (
		.clk(clk), .arst_n(arst_n), .req(upd_req), .rsp(upd_rsp)
	);

	// Checks on the sequencer.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		upd_rsp.done |-> state_q == ST_UPDW)
		else $error("update finished outside its wait state");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> item_stall && !result_valid)
		else $error("activity during the count clearing pass");

	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		cur_bank_q != $past(cur_bank_q) |-> $past(state_q) == ST_NEXT)
		else $error("position bank swapped outside a pass end");

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		upd_start_q |-> ncnt_q != '0 && ncnt_q <= CNT_W'(NB_N))
		else $error("update started with an invalid neighbor count");

endmodule

/* bench/tb_mesh_laplacian_taubin_smoother.sv */
// Self-checking testbench for mesh_laplacian_taubin_smoother: loads a mesh, adds neighbors,
// runs smoothing rounds under many register settings and checks every returned result.
// Depends on mlts_pkg and the smoother RTL.
`timescale 1ns / 1ps

module tb_mesh_laplacian_taubin_smoother;
	import mlts_pkg::*;

	localparam int IDLE_LIMIT  = 600000;
	localparam int SETTLE_CYC  = 20;
	localparam int FOCUS_N     = 64;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	mesh_laplacian_taubin_smoother dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the mesh and of the registers.
	longint          mesh_pos [VTX_N][3];
	longint          mesh_next [VTX_N][3];
	longint          mesh_nrm [VTX_N][3];
	longint          mesh_wt [VTX_N];
	bit              mesh_border [VTX_N];
	int              nb_list [VTX_N][NB_N];
	int              nb_count [VTX_N];
	longint          r_envelope, r_passes, r_maintain, r_edges, r_mode, r_lambda, r_mu, r_vtotal;

	item_t           pending_items[$];
	result_t         expected_results[$];
	int              errors;
	int              items_sent;
	int              results_seen;
	int              runs_done;
	bit              steady_send;
	bit              long_hold_req;
	bit              long_hold_taken;
	int              send_gap;
	int              stall_left;
	int              idle_cycles;

	// Round to nearest, ties away from zero.
	function automatic longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// One Jacobi pass over the walked vertices.
	function automatic void smooth_once(longint factor, int nv);
		longint sum[3], off[3], k, g, m, d, nt;
		longint unsigned sq;
		int cnt;
		mesh_next = mesh_pos;
		for (int v = 0; v < nv; v++) begin
			cnt = nb_count[v];
			if ((mesh_border[v] && r_edges == 0) || cnt == 0)
				continue;
			sum = '{0, 0, 0};
			for (int i = 0; i < cnt; i++)
				for (int c = 0; c < 3; c++)
					sum[c] += mesh_pos[nb_list[v][i]][c];
			k = round_shift(r_envelope * mesh_wt[v], GAIN_FRAC);
			g = round_shift(k * factor, GAIN_FRAC);
			sq = 0;
			for (int c = 0; c < 3; c++) begin
				d = sum[c] / longint'(cnt) - mesh_pos[v][c];
				off[c] = clamp32(round_shift(d * g, GAIN_FRAC));
				sq += longint'(off[c] * off[c]);
			end
			m = round_shift(longint'(int_sqrt(sq)) * r_maintain, GAIN_FRAC);
			for (int c = 0; c < 3; c++) begin
				nt = round_shift(mesh_nrm[v][c] * m, NORM_FRAC);
				mesh_next[v][c] = clamp32(mesh_pos[v][c] + off[c] + nt);
			end
		end
		mesh_pos = mesh_next;
	endfunction

	// Apply one accepted item to the shadow mesh and queue the result it causes.
	function automatic void mesh_predict(item_t it);
		result_t r;
		int vi, nv;
		longint f;
		vi = it.vertex_index;
		r = '0;
		r.result_index = it.vertex_index;
		r.status = STAT_ERR;
		case (it.command)
			CMD_RUN: begin
				r.result_index = '0;
				r.status = STAT_DONE;
				nv = (r_vtotal < VTX_N) ? int'(r_vtotal) : VTX_N;
				if (r_envelope != 0 && r_passes != 0)
					for (int rd = 0; rd < (r_mode != 0 ? 2 : 1); rd++) begin
						f = (rd == 0) ? r_lambda : r_mu - r_lambda;
						for (int p = 0; p < r_passes; p++)
							smooth_once(f, nv);
					end
				expected_results.push_back(r);
			end
			CMD_LOAD: begin
				mesh_pos[vi] = '{it.pos_x, it.pos_y, it.pos_z};
				mesh_nrm[vi] = '{it.normal_x, it.normal_y, it.normal_z};
				mesh_wt[vi] = it.paint_weight;
				mesh_border[vi] = it.on_border;
				nb_count[vi] = 0;
			end
			CMD_ADD: begin
				if (nb_count[vi] >= NB_N) begin
					expected_results.push_back(r);
				end else begin
					nb_list[vi][nb_count[vi]] = it.neighbor_index;
					nb_count[vi]++;
				end
			end
			default: begin
				r.out_x = mesh_pos[vi][0];
				r.out_y = mesh_pos[vi][1];
				r.out_z = mesh_pos[vi][2];
				r.status = STAT_READ;
				expected_results.push_back(r);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	function automatic logic signed [31:0] rand_pos();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return int'($urandom_range(0, 4194304)) - 2097152;
	endfunction

	function automatic logic signed [15:0] rand_normal();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 5) == 0)
			return w[15:0];
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic item_t make_item(logic [1:0] cmd, int vi, int ni);
		item_t it;
		logic [31:0] w;
		w = $urandom;
		it.command = cmd;
		it.vertex_index = vi;
		it.neighbor_index = ni;
		it.pos_x = rand_pos();
		it.pos_y = rand_pos();
		it.pos_z = rand_pos();
		it.normal_x = rand_normal();
		it.normal_y = rand_normal();
		it.normal_z = rand_normal();
		it.paint_weight = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
				: $urandom_range(0, 65536);
		it.on_border = w[0];
		return it;
	endfunction

	function automatic longint pick_gain();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 65536;
			2: return 131071;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (steady_send || sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sender: offers queued items, counts a transfer on valid without stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				mesh_predict(pending_items.pop_front());
				items_sent++;
				send_gap = pick_gap();
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item_valid <= 1'b1;
					item <= pending_items[0];
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			long_hold_taken = 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("MISMATCH unexpected result index %0d status %0d",
						result.result_index, result.status);
					errors++;
				end else begin
					result_t want;
					want = expected_results.pop_front();
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.result_index !== want.result_index)
						report_mismatch("result_index", result.result_index, want.result_index);
					if (result.out_x !== want.out_x)
						report_mismatch("out_x", result.out_x, want.out_x);
					if (result.out_y !== want.out_y)
						report_mismatch("out_y", result.out_y, want.out_y);
					if (result.out_z !== want.out_z)
						report_mismatch("out_z", result.out_z, want.out_z);
				end
			end
			if (long_hold_req && !long_hold_taken) begin
				long_hold_taken = 1'b1;
				stall_left = 400;
			end else if (stall_left == 0 && !steady_send) begin
				int sel;
				sel = $urandom_range(0, 99);
				if (sel >= 92)
					stall_left = $urandom_range(5, 40);
				else if (sel >= 65)
					stall_left = $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Wait until every queued item went in and every expected result came out.
	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[CFG_DW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENVELOPE: r_envelope = val & 17'h1ffff;
			REG_PASSES:   r_passes = val & 9'h1ff;
			REG_MAINTAIN: r_maintain = val & 17'h1ffff;
			REG_EDGES:    r_edges = val & 1;
			REG_MODE:     r_mode = val & 1;
			REG_LAMBDA:   r_lambda = val & 17'h1ffff;
			REG_MU:       r_mu = val & 17'h1ffff;
			default:      r_vtotal = val & 11'h7ff;
		endcase
	endtask

	task automatic write_all(longint env, longint passes, longint maint, longint edges,
			longint mode, longint lam, longint mu, longint vtot);
		write_reg(REG_ENVELOPE, env);
		write_reg(REG_PASSES, passes);
		write_reg(REG_MAINTAIN, maint);
		write_reg(REG_EDGES, edges);
		write_reg(REG_MODE, mode);
		write_reg(REG_LAMBDA, lam);
		write_reg(REG_MU, mu);
		write_reg(REG_VTOTAL, vtot);
	endtask

	// Stimulus.
	initial begin
		item_t it;
		longint env, passes, vtot;
		int sel;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		runs_done = 0;
		steady_send = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles = 0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		r_envelope = 65536; r_passes = 0; r_maintain = 0; r_edges = 0;
		r_mode = 0; r_lambda = 32768; r_mu = 197; r_vtotal = 0;
		for (int v = 0; v < VTX_N; v++) begin
			mesh_pos[v] = '{0, 0, 0};
			mesh_nrm[v] = '{0, 0, 0};
			mesh_wt[v] = 0;
			mesh_border[v] = 0;
			nb_count[v] = 0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole mesh so that every walked or neighbor vertex holds data.
		for (int v = 0; v < VTX_N; v++)
			pending_items.push_back(make_item(CMD_LOAD, v, 0));
		drain();

		// Directed: extreme positions, normals and weights, a full list, reads, runs.
		it = make_item(CMD_LOAD, 0, 0);
		it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh7fffffff; it.pos_z = 32'sh80000000;
		it.normal_x = 16384; it.normal_y = -16384; it.normal_z = 0;
		it.paint_weight = 131071; it.on_border = 1'b0;
		pending_items.push_back(it);
		it.vertex_index = 1;
		it.pos_x = 32'sh80000000; it.pos_y = 32'sh80000000; it.pos_z = 32'sh7fffffff;
		it.paint_weight = 65536; it.on_border = 1'b1;
		pending_items.push_back(it);
		it.vertex_index = 2; it.paint_weight = 0; it.on_border = 1'b0;
		pending_items.push_back(it);
		// Seventeen adds: the last one finds the list full.
		for (int i = 0; i < NB_N + 1; i++)
			pending_items.push_back(make_item(CMD_ADD, 0, i[0] ? 1 : 1023));
		pending_items.push_back(make_item(CMD_ADD, 1, 0));
		pending_items.push_back(make_item(CMD_READ, 0, 0));
		pending_items.push_back(make_item(CMD_RUN, 0, 0));
		pending_items.push_back(make_item(CMD_READ, 1023, 0));
		drain();
		write_all(65536, 1, 131071, 1, 1, 131071, 0, 8);
		pending_items.push_back(make_item(CMD_RUN, 0, 0));
		for (int v = 0; v < 3; v++)
			pending_items.push_back(make_item(CMD_READ, v, 0));
		drain();
		// Many passes with zero strength leave the mesh alone.
		write_all(0, 300, 65536, 0, 0, 65536, 65536, 2047);
		pending_items.push_back(make_item(CMD_RUN, 0, 0));
		pending_items.push_back(make_item(CMD_READ, 0, 0));
		drain();

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < 20; ph++) begin
			env = pick_gain();
			passes = (env == 0) ? $urandom_range(0, 300) : $urandom_range(0, 2);
			case ($urandom_range(0, 4))
				0: vtot = 0;
				1: vtot = 1024;
				2: vtot = 2047;
				default: vtot = $urandom_range(1, FOCUS_N);
			endcase
			write_all(env, passes, pick_gain(), $urandom_range(0, 1), $urandom_range(0, 1),
				pick_gain(), pick_gain(), vtot);
			steady_send = (ph % 5 == 4);
			for (int i = 0; i < 30; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 50)
					it = make_item(CMD_ADD, $urandom_range(0, FOCUS_N - 1), $urandom_range(0, 1023));
				else if (sel < 75)
					it = make_item(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					it = make_item(CMD_LOAD, $urandom_range(0, FOCUS_N - 1), $urandom_range(0, 1023));
				pending_items.push_back(it);
			end
			pending_items.push_back(make_item(CMD_RUN, $urandom_range(0, 1023), 0));
			runs_done++;
			// Hold the receiver off once while reads keep coming, so the block backs up.
			if (ph == 7) begin
				steady_send = 1'b1;
				long_hold_req = 1'b1;
			end
			for (int i = 0; i < 6; i++)
				pending_items.push_back(make_item(CMD_READ, $urandom_range(0, FOCUS_N - 1), 0));
			if (ph == 7)
				for (int i = 0; i < 40; i++)
					pending_items.push_back(make_item(CMD_READ, $urandom_range(0, 1023), 0));
			drain();
		end

		steady_send = 1'b0;
		drain();
		repeat (100) @(posedge clk);
		if (expected_results.size() > 0) begin
			$display("MISMATCH %0d expected results never arrived", expected_results.size());
			errors++;
		end
		$display("Covered %0d items, %0d results and %0d random smoothing rounds, %0d errors.",
			items_sent, results_seen, runs_done, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
